// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL.
// Each macro expects clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/aph_pkg.sv
// ----------------------------------------------------------------------------
// aph_pkg
// Types, constants and helpers for the audio packet header parser.
// ----------------------------------------------------------------------------
package aph_pkg;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [0:0] REG_CHIP_VARIANT = 1'b0;

    localparam logic [7:0] SYNC_FIRST  = 8'h12;
    localparam logic [7:0] SYNC_SECOND = 8'h34;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_LEN = 2'd1;
    localparam logic [1:0] STATUS_TRUNC   = 2'd2;

    typedef enum logic [3:0] {
        PH_HUNT  = 4'd0,
        PH_SYNC2 = 4'd1,
        PH_ID    = 4'd2,
        PH_CTR   = 4'd3,
        PH_LEN0  = 4'd4,
        PH_LEN1  = 4'd5,
        PH_LEN2  = 4'd6,
        PH_LEN3  = 4'd7
    } phase_t;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       end_of_data;
    } byte_item_t;

    typedef struct packed {
        logic [1:0]  header_status;
        logic [11:0] path_id;
        logic [7:0]  packet_counter;
        logic [31:0] payload_length;
    } hdr_item_t;

    function automatic logic length_allowed(input logic [31:0] len);
        return (len == 32'd160) || (len == 32'd256) || (len == 32'd320) ||
               (len == 32'd480) || (len == 32'd640) || (len == 32'd1280);
    endfunction

endpackage

// File: sv/aph_cfg.sv
// ----------------------------------------------------------------------------
// aph_cfg
// APB register file holding the chip variant select.
// ----------------------------------------------------------------------------
module aph_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [aph_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [aph_pkg::APB_DATA_W-1:0] pwdata,
    output logic [aph_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output logic                           chip_variant
);

    logic chip_variant_reg;
    logic chip_variant_next;
    logic wr_en;
    logic reg_hit;

    // word index sits above the byte offset
    assign reg_hit = (paddr[aph_pkg::APB_ADDR_W-1:2] == aph_pkg::REG_CHIP_VARIANT);
    assign wr_en   = psel && penable && pwrite && reg_hit;
    assign pready  = 1'b1;

    always_comb
    begin
        chip_variant_next = chip_variant_reg;
        if (wr_en)
        begin
            chip_variant_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chip_variant_reg <= 1'b0;
        end
        else
        begin
            chip_variant_reg <= chip_variant_next;
        end
    end

    assign prdata = reg_hit ? {{(aph_pkg::APB_DATA_W-1){1'b0}}, chip_variant_reg}
                            : '0;
    assign chip_variant = chip_variant_reg;

endmodule

// File: sv/aph_parse.sv
// ----------------------------------------------------------------------------
// aph_parse
// Sync hunt and header field capture, one byte per transfer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aph_parse (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                chip_variant,
    input  logic                in_fire,
    input  aph_pkg::byte_item_t in_item,
    output logic                res_valid,
    output aph_pkg::hdr_item_t  res_item
);

    aph_pkg::phase_t phase_reg;
    aph_pkg::phase_t phase_next;
    aph_pkg::phase_t phase_step;
    logic [11:0]     id_reg;
    logic [11:0]     id_next;
    logic [11:0]     id_step;
    logic [7:0]      ctr_reg;
    logic [7:0]      ctr_next;
    logic [7:0]      ctr_step;
    logic [31:0]     len_reg;
    logic [31:0]     len_next;
    logic [31:0]     len_step;
    logic            done;
    logic [7:0]      b;
    logic            last;

    assign b    = in_item.stream_byte;
    assign last = in_item.end_of_data;

    // next state for the current byte
    always_comb
    begin
        phase_step = phase_reg;
        id_step    = id_reg;
        ctr_step   = ctr_reg;
        len_step   = len_reg;
        done       = 1'b0;
        case (phase_reg)
            aph_pkg::PH_SYNC2:
            begin
                if (b == aph_pkg::SYNC_SECOND)
                begin
                    phase_step = aph_pkg::PH_ID;
                end
                else if (b == aph_pkg::SYNC_FIRST)
                begin
                    phase_step = aph_pkg::PH_SYNC2;
                end
                else
                begin
                    phase_step = aph_pkg::PH_HUNT;
                end
            end
            aph_pkg::PH_ID:
            begin
                id_step    = {4'h0, b};
                phase_step = aph_pkg::PH_CTR;
            end
            aph_pkg::PH_CTR:
            begin
                if (!chip_variant)
                begin
                    id_step  = {b[7:4], id_reg[7:0]};
                    ctr_step = {4'h0, b[3:0]};
                end
                else
                begin
                    ctr_step = b;
                end
                len_step   = '0;
                phase_step = aph_pkg::PH_LEN0;
            end
            aph_pkg::PH_LEN0:
            begin
                len_step[7:0] = b;
                phase_step    = aph_pkg::PH_LEN1;
            end
            aph_pkg::PH_LEN1:
            begin
                len_step[15:8] = b;
                phase_step     = aph_pkg::PH_LEN2;
            end
            aph_pkg::PH_LEN2:
            begin
                len_step[23:16] = b;
                phase_step      = aph_pkg::PH_LEN3;
            end
            aph_pkg::PH_LEN3:
            begin
                len_step[31:24] = b;
                done            = 1'b1;
                phase_step      = aph_pkg::PH_HUNT;
            end
            default:
            begin
                // hunting, and any unused code
                phase_step = (b == aph_pkg::SYNC_FIRST) ? aph_pkg::PH_SYNC2
                                                        : aph_pkg::PH_HUNT;
            end
        endcase
    end

    // register update: end of data clears the parser
    always_comb
    begin
        phase_next = phase_reg;
        id_next    = id_reg;
        ctr_next   = ctr_reg;
        len_next   = len_reg;
        if (in_fire)
        begin
            if (last)
            begin
                phase_next = aph_pkg::PH_HUNT;
                id_next    = '0;
                ctr_next   = '0;
                len_next   = '0;
            end
            else
            begin
                phase_next = phase_step;
                id_next    = id_step;
                ctr_next   = ctr_step;
                len_next   = len_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= aph_pkg::PH_HUNT;
            id_reg    <= '0;
            ctr_reg   <= '0;
            len_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            id_reg    <= id_next;
            ctr_reg   <= ctr_next;
            len_reg   <= len_next;
        end
    end

    // result for this byte, if any
    always_comb
    begin
        res_item = '0;
        if (done)
        begin
            res_item.header_status  = aph_pkg::length_allowed(len_step)
                                      ? aph_pkg::STATUS_OK : aph_pkg::STATUS_BAD_LEN;
            res_item.path_id        = id_step;
            res_item.packet_counter = ctr_step;
            res_item.payload_length = len_step;
        end
        else
        begin
            res_item.header_status  = aph_pkg::STATUS_TRUNC;
        end
    end

    assign res_valid = in_fire && (done || last);

    `ASSERT_IMP(a_hdr_from_len3,
        res_valid && (res_item.header_status != aph_pkg::STATUS_TRUNC),
        phase_reg == aph_pkg::PH_LEN3, "header result outside last length byte")
    `ASSERT_NXT(a_last_clears, in_fire && last,
        (phase_reg == aph_pkg::PH_HUNT) && (len_reg == 32'd0), "end of data did not clear parser")
    `ASSERT_IMP(a_trunc_only_last,
        res_valid && (res_item.header_status == aph_pkg::STATUS_TRUNC),
        last && !done, "truncated result without end of data")

endmodule

// File: sv/aph_out.sv
// ----------------------------------------------------------------------------
// aph_out
// Result register plus skid register toward the output channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aph_out (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               res_valid,
    input  aph_pkg::hdr_item_t res_item,
    input  logic               hdr_stall,
    output logic               hdr_valid,
    output aph_pkg::hdr_item_t hdr_data,
    output logic               full
);

    logic               out_valid_reg;
    logic               out_valid_next;
    logic               skid_valid_reg;
    logic               skid_valid_next;
    aph_pkg::hdr_item_t out_data_reg;
    aph_pkg::hdr_item_t out_data_next;
    aph_pkg::hdr_item_t skid_data_reg;
    aph_pkg::hdr_item_t skid_data_next;
    logic               out_free;

    // output slot can take data when empty or being drained this cycle
    assign out_free = !out_valid_reg || !hdr_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            // input is stalled here, so no new result arrives
            if (out_free)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (out_free)
            begin
                out_valid_next = 1'b1;
                out_data_next  = res_item;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = res_item;
            end
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign hdr_valid = out_valid_reg;
    assign hdr_data  = out_data_reg;
    assign full      = skid_valid_reg;

    `ASSERT_IMP(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid holds data while output is empty")
    `ASSERT_IMP(a_no_res_when_full, skid_valid_reg, !res_valid, "result arrived while skid is full")
    `ASSERT_NXT(a_stall_keeps_valid, out_valid_reg && hdr_stall, out_valid_reg, "output dropped under stall")

endmodule

// File: sv/audio_packet_header_parser.sv
// ----------------------------------------------------------------------------
// audio_packet_header_parser
// Byte-stream sync hunter and audio packet header decoder.
// ----------------------------------------------------------------------------
// Takes one stream byte per clock unless stalled. A result for the byte that
// completes a header, or for a byte flagged end_of_data, enters the output
// register, or the skid register under a stall. The parser state update is a
// single registered step per byte; an output and a skid register follow it,
// so the input stalls only once two results are waiting downstream.
// chip_variant is taken when the counter byte passes. The user must write it
// over APB at byte address 0 while the block is idle; it is not enforced.
module audio_packet_header_parser (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           byte_valid,
    output logic                           byte_stall,
    input  aph_pkg::byte_item_t            byte_data,
    output logic                           hdr_valid,
    input  logic                           hdr_stall,
    output aph_pkg::hdr_item_t             hdr_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [aph_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [aph_pkg::APB_DATA_W-1:0] pwdata,
    output logic [aph_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    logic               chip_variant;
    logic               in_fire;
    logic               res_valid;
    aph_pkg::hdr_item_t res_item;
    logic               out_full;

    assign byte_stall = out_full;
    assign in_fire    = byte_valid && !byte_stall;

    aph_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .chip_variant (chip_variant)
    );

    aph_parse u_parse (
        .clk          (clk),
        .rst_n        (rst_n),
        .chip_variant (chip_variant),
        .in_fire      (in_fire),
        .in_item      (byte_data),
        .res_valid    (res_valid),
        .res_item     (res_item)
    );

    aph_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_item  (res_item),
        .hdr_stall (hdr_stall),
        .hdr_valid (hdr_valid),
        .hdr_data  (hdr_data),
        .full      (out_full)
    );

endmodule

// File: test/audio_packet_header_parser_tb.sv
// ----------------------------------------------------------------------------
// audio_packet_header_parser_tb
// Self-checking bench for the audio packet header parser.
// ----------------------------------------------------------------------------
// Drives byte transfers in random bursts against a receiver with its own
// stall pattern. A scoreboard object runs a cycle-free model of the parser
// on every accepted byte, queues the predicted header results and compares
// each result transfer field by field. chip_variant is rewritten over APB
// between phases and read back.
module audio_packet_header_parser_tb;
    import aph_pkg::*;

    localparam int          CLK_PERIOD     = 20;
    localparam int unsigned TIMEOUT_CYCLES = 200_000;
    localparam int          PHASE_BYTES    = 155;
    localparam int          SETTLE_CYCLES  = 4;
    localparam int          LONG_HOLD      = 100;
    localparam logic [APB_ADDR_W-1:0] VARIANT_ADDR = APB_ADDR_W'(REG_CHIP_VARIANT) << 2;

    typedef enum int {RX_FREE, RX_RANDOM, RX_PATTERN, RX_HEAVY} rx_mode_t;

    // ------------------------------------------------------------------------
    // Scoreboard: parser model plus queue of predicted headers
    // ------------------------------------------------------------------------
    class header_scoreboard;
        bit          variant;
        phase_t      phase;
        logic [11:0] id_acc;
        logic [7:0]  ctr_acc;
        logic [31:0] len_acc;
        hdr_item_t   expected_headers[$];
        int          errors;
        int          bytes_seen;
        int          headers_checked;
        int          status_seen[3];

        function new();
            variant = 1'b0;
            clear_parser();
        endfunction

        function void clear_parser();
            phase   = PH_HUNT;
            id_acc  = '0;
            ctr_acc = '0;
            len_acc = '0;
        endfunction

        function void set_variant(bit v);
            variant = v;
        endfunction

        function int pending();
            return expected_headers.size();
        endfunction

        function bit legal_length(logic [31:0] len);
            case (len)
                32'd160, 32'd256, 32'd320, 32'd480, 32'd640, 32'd1280: return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        function void note_error(string msg);
            errors++;
            if (errors <= 10)
                $display("ERROR @%0t: %s", $realtime, msg);
        endfunction

        // Advance the parser by one accepted byte and queue any result.
        function void take_byte(byte_item_t item);
            logic [7:0] b;
            bit         done;
            hdr_item_t  res;
            b    = item.stream_byte;
            done = 1'b0;
            bytes_seen++;
            case (phase)
                PH_SYNC2:
                    if (b == SYNC_SECOND)
                        phase = PH_ID;
                    else if (b == SYNC_FIRST)
                        phase = PH_SYNC2;
                    else
                        phase = PH_HUNT;
                PH_ID:
                begin
                    id_acc = {4'h0, b};
                    phase  = PH_CTR;
                end
                PH_CTR:
                begin
                    if (!variant)
                    begin
                        id_acc[11:8] = b[7:4];
                        ctr_acc      = {4'h0, b[3:0]};
                    end
                    else
                        ctr_acc = b;
                    len_acc = '0;
                    phase   = PH_LEN0;
                end
                PH_LEN0: begin len_acc[7:0]   = b; phase = PH_LEN1; end
                PH_LEN1: begin len_acc[15:8]  = b; phase = PH_LEN2; end
                PH_LEN2: begin len_acc[23:16] = b; phase = PH_LEN3; end
                PH_LEN3:
                begin
                    len_acc[31:24] = b;
                    done           = 1'b1;
                    phase          = PH_HUNT;
                end
                default:
                    phase = (b == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
            endcase

            if (done)
            begin
                res.header_status  = legal_length(len_acc) ? STATUS_OK : STATUS_BAD_LEN;
                res.path_id        = id_acc;
                res.packet_counter = ctr_acc;
                res.payload_length = len_acc;
                expected_headers.push_back(res);
            end
            else if (item.end_of_data)
            begin
                res = '0;
                res.header_status = STATUS_TRUNC;
                expected_headers.push_back(res);
            end
            if (item.end_of_data)
                clear_parser();
        endfunction

        function void check_header(hdr_item_t got);
            hdr_item_t want;
            if (expected_headers.size() == 0)
            begin
                note_error($sformatf("unexpected result: status=%0d id=%03h ctr=%02h len=%08h",
                    got.header_status, got.path_id, got.packet_counter, got.payload_length));
                return;
            end
            want = expected_headers.pop_front();
            headers_checked++;
            if (want.header_status <= STATUS_TRUNC)
                status_seen[want.header_status]++;
            if (got.header_status !== want.header_status)
                note_error($sformatf("header_status exp %0d got %0d",
                    want.header_status, got.header_status));
            if (got.path_id !== want.path_id)
                note_error($sformatf("path_id exp %03h got %03h",
                    want.path_id, got.path_id));
            if (got.packet_counter !== want.packet_counter)
                note_error($sformatf("packet_counter exp %02h got %02h",
                    want.packet_counter, got.packet_counter));
            if (got.payload_length !== want.payload_length)
                note_error($sformatf("payload_length exp %08h got %08h",
                    want.payload_length, got.payload_length));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n      = 1'b0;
    logic                  byte_valid = 1'b0;
    logic                  byte_stall;
    byte_item_t            byte_data  = '0;
    logic                  hdr_valid;
    logic                  hdr_stall  = 1'b0;
    hdr_item_t             hdr_data;
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [APB_ADDR_W-1:0] paddr      = '0;
    logic [APB_DATA_W-1:0] pwdata     = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    audio_packet_header_parser u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .hdr_valid  (hdr_valid),
        .hdr_stall  (hdr_stall),
        .hdr_data   (hdr_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    header_scoreboard sb;
    bit               long_hold_req = 1'b0;
    int               hold_left     = 0;
    int               rx_tick       = 0;
    rx_mode_t         rx_mode       = RX_FREE;
    bit               phase_variant[6] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Transfer monitor: values sampled are the ones present before the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && !byte_stall)
                sb.take_byte(byte_data);
            if (hdr_valid && !hdr_stall)
                sb.check_header(hdr_data);
        end
    end

    // Receiver stall pattern; switches between randomly chosen modes.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                hold_left     = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (rx_tick % 64 == 0)
                rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_tick++;
            if (hold_left > 0)
            begin
                hold_left--;
                hdr_stall <= 1'b1;
            end
            else
                case (rx_mode)
                    RX_FREE:    hdr_stall <= 1'b0;
                    RX_RANDOM:  hdr_stall <= ($urandom_range(0, 99) < 30);
                    RX_PATTERN: hdr_stall <= ((rx_tick % 7) < 3);
                    default:    hdr_stall <= ($urandom_range(0, 99) < 75);
                endcase
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic byte_item_t mk(logic [7:0] b, logic eod);
        byte_item_t item;
        item.stream_byte = b;
        item.end_of_data = eod;
        return item;
    endfunction

    function automatic logic [31:0] pick_length();
        logic [31:0] legal[6];
        logic [31:0] base;
        legal = '{32'd160, 32'd256, 32'd320, 32'd480, 32'd640, 32'd1280};
        base  = legal[$urandom_range(0, 5)];
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return base;
            6:                return $urandom;
            7:                return base ^ (32'd1 << $urandom_range(0, 31));
            8:                return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
            default:          return base | (32'($urandom_range(1, 255)) << 24);
        endcase
    endfunction

    // Mostly well-formed headers, some broken syncs and hunt-time noise.
    function automatic void add_random_items(ref byte_item_t q[$], input int target);
        logic [7:0]  hdr[8];
        logic [31:0] len;
        int          count;
        int          eod_at;
        int          r;
        count = 0;
        while (count < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
            begin
                len = pick_length();
                hdr = '{SYNC_FIRST, SYNC_SECOND, 8'($urandom), 8'($urandom),
                        len[7:0], len[15:8], len[23:16], len[31:24]};
                r = $urandom_range(0, 99);
                eod_at = (r < 6) ? 7 : (r < 12) ? $urandom_range(0, 6) : -1;
                if ($urandom_range(0, 9) == 0)
                begin
                    q.push_back(mk(SYNC_FIRST, 1'b0));
                    count++;
                end
                for (int i = 0; i < 8; i++)
                begin
                    q.push_back(mk(hdr[i], i == eod_at));
                    count++;
                    if (i == eod_at)
                        break;
                end
            end
            else if (r < 80)
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        q.push_back(mk(SYNC_FIRST, 1'b0));
                        q.push_back(mk(8'($urandom), 1'b0));
                        count += 2;
                    end
                    1:
                    begin
                        // partial header: whatever follows fills the fields
                        q.push_back(mk(SYNC_FIRST, 1'b0));
                        q.push_back(mk(SYNC_SECOND, 1'b0));
                        q.push_back(mk(8'($urandom), 1'b0));
                        count += 3;
                    end
                    default:
                    begin
                        q.push_back(mk(8'($urandom), 1'b1));
                        count++;
                    end
                endcase
            end
            else
                repeat ($urandom_range(1, 6))
                begin
                    case ($urandom_range(0, 5))
                        0:       q.push_back(mk(SYNC_SECOND, 1'b0));
                        1:       q.push_back(mk(SYNC_FIRST, 1'b0));
                        default: q.push_back(mk(8'($urandom), 1'b0));
                    endcase
                    count++;
                end
        end
    endfunction

    // Sender: random bursts separated by random gaps unless no_gaps is set.
    task automatic send_bytes(input byte_item_t q[$], input bit no_gaps);
        int burst_left;
        int gap;
        burst_left = 0;
        for (int i = 0; i < q.size(); i++)
        begin
            if (!no_gaps && burst_left == 0)
            begin
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 15)
                                                   : $urandom_range(0, 3);
                burst_left = $urandom_range(1, 24);
                if (gap > 0)
                begin
                    byte_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            byte_valid <= 1'b1;
            byte_data  <= q[i];
            do @(posedge clk); while (byte_stall);
            burst_left--;
        end
        byte_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    task automatic apb_access(input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= VARIANT_ADDR;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        if (wr)
            sb.set_variant(wdata[0]);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_variant_reg(input bit v);
        logic [31:0] rd;
        apb_access(1'b0, '0, rd);
        if (rd !== {31'b0, v})
            sb.note_error($sformatf("chip_variant readback exp %0d got %08h", v, rd));
    endtask

    task automatic program_variant(input bit v);
        logic [31:0] wd;
        logic [31:0] rd;
        wait_drained();
        // parser may still be stepping a byte that produced no result
        repeat (SETTLE_CYCLES) @(posedge clk);
        wd    = $urandom;
        wd[0] = v;
        apb_access(1'b1, wd, rd);
        check_variant_reg(v);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        byte_item_t q[$];
        byte_item_t half[$];
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_variant_reg(1'b0);

        // Directed: end of data while hunting, resync on a repeated first sync
        // byte with all-ones fields, header completing on the last byte,
        // broken sync pair, truncation mid-header.
        q = {};
        q.push_back(mk(8'h00, 1'b1));
        q.push_back(mk(SYNC_FIRST, 1'b0));
        q.push_back(mk(SYNC_FIRST, 1'b0));
        q.push_back(mk(SYNC_SECOND, 1'b0));
        q.push_back(mk(8'hFF, 1'b0));
        q.push_back(mk(8'hFF, 1'b0));
        q.push_back(mk(8'hA0, 1'b0));
        q.push_back(mk(8'h00, 1'b0));
        q.push_back(mk(8'h00, 1'b0));
        q.push_back(mk(8'h00, 1'b0));
        q.push_back(mk(SYNC_FIRST, 1'b0));
        q.push_back(mk(SYNC_SECOND, 1'b0));
        q.push_back(mk(8'h00, 1'b0));
        q.push_back(mk(8'h00, 1'b0));
        q.push_back(mk(8'hFF, 1'b0));
        q.push_back(mk(8'hFF, 1'b0));
        q.push_back(mk(8'hFF, 1'b0));
        q.push_back(mk(8'hFF, 1'b1));
        q.push_back(mk(SYNC_FIRST, 1'b0));
        q.push_back(mk(8'h56, 1'b0));
        q.push_back(mk(SYNC_FIRST, 1'b0));
        q.push_back(mk(SYNC_SECOND, 1'b0));
        q.push_back(mk(8'h55, 1'b1));
        send_bytes(q, 1'b0);

        foreach (phase_variant[p])
        begin
            program_variant(phase_variant[p]);
            q = {};
            add_random_items(q, PHASE_BYTES);
            if (p == 1)
            begin
                // receiver holds off while bytes keep coming: block backs up
                long_hold_req = 1'b1;
                send_bytes(q, 1'b1);
            end
            else if (p == 3)
            begin
                half = q[0:q.size()/2];
                q    = q[q.size()/2+1:$];
                send_bytes(half, 1'b0);
                wait_drained();
                send_bytes(q, 1'b0);
            end
            else
                send_bytes(q, p == 2);
        end

        wait_drained();
        repeat (8) @(posedge clk);
        $display("Run covered %0d byte transfers and %0d header results (%0d ok, %0d bad",
            sb.bytes_seen, sb.headers_checked, sb.status_seen[0], sb.status_seen[1]);
        $display("length, %0d truncated) over both chip variants; %0d errors.",
            sb.status_seen[2], sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/aph_pkg.sv
sv/aph_cfg.sv
sv/aph_parse.sv
sv/aph_out.sv
sv/audio_packet_header_parser.sv
test/audio_packet_header_parser_tb.sv
